// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst_sig is high.
`define ASSERT_SAME(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while rst_sig is high.
`define ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/ttafsm_pkg.sv -----
// Package: state, alarm, LED and register codes for the threshold alarm.
package ttafsm_pkg;

  localparam int TEMP_WIDTH_DEF = 16;

  localparam int STATE_W = 4;
  localparam int ALARM_W = 3;
  localparam int LED_W   = 2;

  localparam logic [STATE_W-1:0] ST_NORM_1 = 4'd0;
  localparam logic [STATE_W-1:0] ST_NORM_2 = 4'd1;
  localparam logic [STATE_W-1:0] ST_NORM_3 = 4'd2;
  localparam logic [STATE_W-1:0] ST_WHI_1  = 4'd3;
  localparam logic [STATE_W-1:0] ST_WHI_2  = 4'd4;
  localparam logic [STATE_W-1:0] ST_CHI    = 4'd5;
  localparam logic [STATE_W-1:0] ST_WLO_1  = 4'd6;
  localparam logic [STATE_W-1:0] ST_WLO_2  = 4'd7;
  localparam logic [STATE_W-1:0] ST_CLO    = 4'd8;

  localparam logic [ALARM_W-1:0] AL_NONE    = 3'd0;
  localparam logic [ALARM_W-1:0] AL_HI_WARN = 3'd1;
  localparam logic [ALARM_W-1:0] AL_LO_WARN = 3'd2;
  localparam logic [ALARM_W-1:0] AL_HI_CRIT = 3'd3;
  localparam logic [ALARM_W-1:0] AL_LO_CRIT = 3'd4;

  localparam logic [LED_W-1:0] LED_OFF  = 2'd0;
  localparam logic [LED_W-1:0] LED_SLOW = 2'd1;
  localparam logic [LED_W-1:0] LED_FAST = 2'd2;

  localparam int NUM_THR   = 4;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_HIGH_CRIT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_HIGH_WARN = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LOW_CRIT  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_LOW_WARN  = 2'd3;

  localparam int HIGH_CRIT_RESET = 100;
  localparam int HIGH_WARN_RESET = 80;
  localparam int LOW_CRIT_RESET  = 0;
  localparam int LOW_WARN_RESET  = 10;

  typedef struct packed {
    logic [ALARM_W-1:0] alarm;
    logic [LED_W-1:0]   led;
    logic [STATE_W-1:0] state;
  } res_t;

endpackage

// ----- hw/rtl/ttafsm_cfg_regs.sv -----
// Threshold registers with reset defaults, written through the plain write port.
module ttafsm_cfg_regs #(
  parameter int TEMP_WIDTH = ttafsm_pkg::TEMP_WIDTH_DEF
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                cfg_we,
  input  logic [ttafsm_pkg::REG_IDX_W-1:0]                    cfg_index,
  input  logic [TEMP_WIDTH-1:0]                               cfg_data,
  output logic [TEMP_WIDTH-1:0]                               high_critical,
  output logic [TEMP_WIDTH-1:0]                               high_warning,
  output logic [TEMP_WIDTH-1:0]                               low_critical,
  output logic [TEMP_WIDTH-1:0]                               low_warning
);
  import ttafsm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_critical <= TEMP_WIDTH'(HIGH_CRIT_RESET);
      high_warning  <= TEMP_WIDTH'(HIGH_WARN_RESET);
      low_critical  <= TEMP_WIDTH'(LOW_CRIT_RESET);
      low_warning   <= TEMP_WIDTH'(LOW_WARN_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HIGH_CRIT: high_critical <= cfg_data;
        REG_HIGH_WARN: high_warning  <= cfg_data;
        REG_LOW_CRIT:  low_critical  <= cfg_data;
        REG_LOW_WARN:  low_warning   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/ttafsm_next.sv -----
// Next-state, alarm and LED logic for one sample.
module ttafsm_next #(
  parameter int TEMP_WIDTH = ttafsm_pkg::TEMP_WIDTH_DEF
) (
  input  logic [ttafsm_pkg::STATE_W-1:0] state,
  input  logic                           mode,
  input  logic [TEMP_WIDTH-1:0]          temperature,
  input  logic [TEMP_WIDTH-1:0]          high_critical,
  input  logic [TEMP_WIDTH-1:0]          high_warning,
  input  logic [TEMP_WIDTH-1:0]          low_critical,
  input  logic [TEMP_WIDTH-1:0]          low_warning,
  output ttafsm_pkg::res_t               res
);
  import ttafsm_pkg::*;

  logic                ge_hc;
  logic                ge_hw;
  logic                le_lc;
  logic                le_lw;
  logic [ALARM_W-1:0]  alarm;
  logic [STATE_W-1:0]  st;

  assign ge_hc = $signed(temperature) >= $signed(high_critical);
  assign ge_hw = $signed(temperature) >= $signed(high_warning);
  assign le_lc = $signed(temperature) <= $signed(low_critical);
  assign le_lw = $signed(temperature) <= $signed(low_warning);

  always_comb begin
    alarm = AL_NONE;
    st    = state;
    if (mode) begin
      st = ST_NORM_1;
    end else begin
      case (state)
        ST_NORM_1: begin
          if (ge_hw) begin
            alarm = AL_HI_WARN;
            st    = ST_WHI_1;
          end else if (le_lw) begin
            alarm = AL_LO_WARN;
            st    = ST_WLO_1;
          end
        end
        ST_NORM_2: begin
          if (ge_hw) begin
            alarm = AL_HI_WARN;
            st    = ST_WHI_1;
          end else if (le_lw) begin
            st = ST_WLO_1;
          end
        end
        ST_NORM_3: begin
          if (le_lw) begin
            alarm = AL_LO_WARN;
            st    = ST_WLO_1;
          end else if (ge_hw) begin
            st = ST_WHI_1;
          end
        end
        ST_WHI_1: begin
          if (ge_hc) begin
            alarm = AL_HI_CRIT;
            st    = ST_CHI;
          end else if (!ge_hw) begin
            st = ST_NORM_3;
          end
        end
        ST_WHI_2: begin
          if (ge_hc) st = ST_CHI;
          else if (!ge_hw) st = ST_NORM_3;
        end
        ST_CHI: begin
          if (!ge_hc) st = ST_WHI_2;
        end
        ST_WLO_1: begin
          if (le_lc) begin
            alarm = AL_LO_CRIT;
            st    = ST_CLO;
          end else if (!le_lw) begin
            st = ST_NORM_2;
          end
        end
        ST_WLO_2: begin
          if (le_lc) st = ST_CLO;
          else if (!le_lw) st = ST_NORM_2;
        end
        ST_CLO: begin
          if (!le_lc) st = ST_WLO_2;
        end
        default: st = ST_NORM_1;
      endcase
    end
  end

  always_comb begin
    res.alarm = alarm;
    res.state = st;
    case (st)
      ST_CHI, ST_CLO:                       res.led = LED_FAST;
      ST_WHI_1, ST_WHI_2, ST_WLO_1, ST_WLO_2: res.led = LED_SLOW;
      default:                              res.led = LED_OFF;
    endcase
  end

endmodule

// ----- hw/rtl/temperature_threshold_alarm_fsm_core.sv -----
// Top level: input register, alarm state update and result register.
// A request is captured in the input register, then its result in the result register.
// Throughput: one request per cycle while out_stall is low; the state update is combinational logic.
// Under out_stall the input register takes one more request, then in_stall rises.
// Reset: pipeline valids clear, state goes to the first normal state,
// thresholds return to their defaults.
module temperature_threshold_alarm_fsm_core #(
  parameter int TEMP_WIDTH = ttafsm_pkg::TEMP_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ttafsm_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [TEMP_WIDTH-1:0]               cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                mode,
  input  logic [TEMP_WIDTH-1:0]               temperature,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ttafsm_pkg::ALARM_W-1:0]      alarm_code,
  output logic [ttafsm_pkg::LED_W-1:0]        led_pattern,
  output logic [ttafsm_pkg::STATE_W-1:0]      level_state
);
  import ttafsm_pkg::*;

  logic [TEMP_WIDTH-1:0] high_critical;
  logic [TEMP_WIDTH-1:0] high_warning;
  logic [TEMP_WIDTH-1:0] low_critical;
  logic [TEMP_WIDTH-1:0] low_warning;

  logic                  s1_valid;
  logic                  s1_mode;
  logic [TEMP_WIDTH-1:0] s1_temp;
  logic                  s1_adv;
  logic [STATE_W-1:0]    state;
  res_t                  res_next;

  ttafsm_cfg_regs #(
    .TEMP_WIDTH(TEMP_WIDTH)
  ) u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .high_critical(high_critical),
    .high_warning (high_warning),
    .low_critical (low_critical),
    .low_warning  (low_warning)
  );

  ttafsm_next #(
    .TEMP_WIDTH(TEMP_WIDTH)
  ) u_next (
    .state        (state),
    .mode         (s1_mode),
    .temperature  (s1_temp),
    .high_critical(high_critical),
    .high_warning (high_warning),
    .low_critical (low_critical),
    .low_warning  (low_warning),
    .res          (res_next)
  );

  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_mode <= mode;
      s1_temp <= temperature;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      state     <= ST_NORM_1;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
      state     <= res_next.state;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      alarm_code  <= res_next.alarm;
      led_pattern <= res_next.led;
      level_state <= res_next.state;
    end
  end

endmodule

// ----- hw/rtl/ttafsm_checker.sv -----
// Port-level checker for the threshold alarm, bound to the top level.
`include "assert_macros.svh"

module ttafsm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [ttafsm_pkg::ALARM_W-1:0] alarm_code,
  input logic [ttafsm_pkg::LED_W-1:0]   led_pattern,
  input logic [ttafsm_pkg::STATE_W-1:0] level_state
);
  import ttafsm_pkg::*;

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(alarm_code) && $stable(led_pattern) && $stable(level_state), "stalled result changed")

  `ASSERT_SAME(a_led_match, clk, rst, out_valid, ((led_pattern == LED_FAST) == (level_state == ST_CHI || level_state == ST_CLO)) && ((led_pattern == LED_OFF) == (level_state == ST_NORM_1 || level_state == ST_NORM_2 || level_state == ST_NORM_3)), "LED pattern does not match state")

  `ASSERT_SAME(a_alarm_state, clk, rst, out_valid && alarm_code != AL_NONE, (alarm_code == AL_HI_WARN && level_state == ST_WHI_1) || (alarm_code == AL_LO_WARN && level_state == ST_WLO_1) || (alarm_code == AL_HI_CRIT && level_state == ST_CHI) || (alarm_code == AL_LO_CRIT && level_state == ST_CLO), "alarm code does not match state")

  `ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid, "result valid right after reset")

endmodule

bind temperature_threshold_alarm_fsm_core ttafsm_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .alarm_code (alarm_code),
  .led_pattern(led_pattern),
  .level_state(level_state)
);
